/* rtl/mpot_pkg.sv */
// Shared types, codes and helpers for the matched pair outcome tally.
package mpot_pkg;

    localparam int MAX_PAIRS_DEF   = 1024;
    localparam int COUNT_WIDTH_DEF = 24;
    localparam int PID_W           = 11;
    localparam int VAL_W           = 32;
    localparam int TALLY_OUT_W     = 24;
    localparam int DIFF_W          = 33;
    localparam int IN_DATA_W       = 48;
    localparam int OUT_DATA_W      = 232;

    // Item kinds carried on the input tuser.
    typedef enum logic [1:0] {
        KIND_OBS   = 2'd0,
        KIND_READ  = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_SPARE = 2'd3
    } kind_t;

    // Back end sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CLEAR,
        ST_REPLY
    } state_t;

    // One arm of a pair entry.
    typedef struct packed {
        logic             found;
        logic             fin;
        logic [VAL_W-1:0] val;
    } slot_t;

    typedef struct packed {
        slot_t trt;
        slot_t ctl;
    } entry_t;

    // A classified item as it waits in the queue.
    typedef struct packed {
        kind_t             kind;
        logic              in_range;
        logic              unmatched;
        logic [PID_W-1:0]  pid;
        logic              treated;
        logic              fin;
        logic              succ;
        logic [VAL_W-1:0]  val;
    } item_t;

    // Status from the back end to the front end.
    typedef struct packed {
        logic init_busy;
        logic pop;
    } back_stat_t;

    // A slot counts as a success when finite and nonzero.
    function automatic logic slot_success(input slot_t s);
        return s.fin && (s.val != '0);
    endfunction

    // Discordance of a pair: bit 1 plus, bit 0 minus.
    function automatic logic [1:0] pair_contrib(input entry_t e);
        logic ts;
        logic cs;
        ts = slot_success(e.trt);
        cs = slot_success(e.ctl);
        if (!(e.trt.found && e.ctl.found)) begin
            return 2'b00;
        end
        return {ts && !cs, !ts && cs};
    endfunction

endpackage

/* rtl/mpot_front.sv */
// Front end: accepts items, classifies them and holds them in a two-entry queue.
module mpot_front #(
    parameter int MAX_PAIRS = mpot_pkg::MAX_PAIRS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [mpot_pkg::IN_DATA_W-1:0] s_tdata,
    input  logic [1:0]                   s_tuser,
    input  mpot_pkg::back_stat_t         stat,
    output logic                         q_valid,
    output mpot_pkg::item_t              q_item
);
    import mpot_pkg::*;

    item_t       slots_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    item_t       cls;
    logic        push;
    logic        pop;

    // Classify the incoming item.
    always_comb begin
        cls.kind      = kind_t'(s_tuser);
        cls.pid       = s_tdata[10:0];
        cls.treated   = s_tdata[11];
        cls.fin       = s_tdata[44];
        cls.val       = cls.fin ? s_tdata[43:12] : '0;
        cls.succ      = cls.fin && (s_tdata[43:12] != '0);
        cls.unmatched = (cls.pid == '0);
        cls.in_range  = !cls.unmatched && (32'(cls.pid) <= 32'(MAX_PAIRS));
    end

    assign s_tready = (count_reg != 2'd2) && !stat.init_busy;
    assign push     = s_tvalid && s_tready;
    assign pop      = stat.pop;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = slots_reg[rd_ptr_reg];

    // Queue storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= cls;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

/* rtl/mpot_back.sv */
// Back end: pair table, counters, clearing pass and the result register.
module mpot_back #(
    parameter int MAX_PAIRS   = mpot_pkg::MAX_PAIRS_DEF,
    parameter int COUNT_WIDTH = mpot_pkg::COUNT_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    input  mpot_pkg::item_t               q_item,
    output mpot_pkg::back_stat_t          stat,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [mpot_pkg::OUT_DATA_W-1:0] m_tdata
);
    import mpot_pkg::*;

    localparam int AW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
    localparam int PW = $clog2(MAX_PAIRS + 1);
    localparam int EW = $bits(entry_t);
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_PAIRS - 1);

    state_t                 state_reg, state_next;
    item_t                  item_reg, item_next;
    logic [AW-1:0]          clr_addr_reg, clr_addr_next;
    logic                   init_reg, init_next;
    logic [COUNT_WIDTH-1:0] tally_reg [4];
    logic [COUNT_WIDTH-1:0] tally_next [4];
    logic [PW-1:0]          plus_reg, plus_next;
    logic [PW-1:0]          minus_reg, minus_next;
    logic [PID_W-1:0]       max_reg, max_next;
    logic                   mvalid_reg, mvalid_next;
    logic [OUT_DATA_W-1:0]  mdata_reg, mdata_next;

    logic [EW-1:0]          mem [MAX_PAIRS];
    logic [EW-1:0]          rd_reg;
    logic [AW-1:0]          rd_addr;
    logic                   we;
    logic [AW-1:0]          wa;
    logic [EW-1:0]          wd;

    logic                   out_free;
    logic                   pop;
    entry_t                 old_e, new_e, sel_e;
    logic [1:0]             old_c, new_c;
    logic [1:0]             tidx;
    logic                   is_obs;
    logic signed [DIFF_W-1:0] diff;
    logic                   dvalid;
    logic [3:0]             flags;
    logic [PW-1:0]          plus_upd, minus_upd;

    assign out_free = !mvalid_reg || m_tready;
    assign rd_addr  = AW'(32'(q_item.pid) - 32'd1);
    assign old_e    = entry_t'(rd_reg);

    // Pair table: one write a cycle, and a registered read that is taken with the item
    // and held while the item waits for the result register.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        if (pop) begin
            rd_reg <= mem[rd_addr];
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid && !init_reg) begin
                    state_next = (q_item.kind == KIND_CLEAR) ? ST_CLEAR : ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_CLEAR: begin
                if (clr_addr_reg == LAST_ADDR) begin
                    state_next = init_reg ? ST_IDLE : ST_REPLY;
                end
            end
            ST_REPLY: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Entry update and the fields derived from it.
    always_comb begin
        is_obs = (item_reg.kind == KIND_OBS);
        new_e  = old_e;
        if (item_reg.treated) begin
            new_e.trt = '{found: 1'b1, fin: item_reg.fin, val: item_reg.val};
        end else begin
            new_e.ctl = '{found: 1'b1, fin: item_reg.fin, val: item_reg.val};
        end
        old_c = pair_contrib(old_e);
        new_c = pair_contrib(new_e);
        if (!item_reg.in_range) begin
            sel_e = '0;
        end else if (is_obs) begin
            sel_e = new_e;
        end else begin
            sel_e = old_e;
        end
        if (!sel_e.trt.found) begin
            sel_e.trt.val = '0;
            sel_e.trt.fin = 1'b0;
        end
        if (!sel_e.ctl.found) begin
            sel_e.ctl.val = '0;
            sel_e.ctl.fin = 1'b0;
        end
        dvalid = sel_e.trt.found && sel_e.ctl.found && sel_e.trt.fin && sel_e.ctl.fin;
        diff   = dvalid ? (DIFF_W'($signed(sel_e.trt.val)) - DIFF_W'($signed(sel_e.ctl.val)))
                        : '0;
        flags  = {sel_e.ctl.fin, sel_e.trt.fin, sel_e.ctl.found, sel_e.trt.found};
        plus_upd  = plus_reg - PW'(old_c[1]) + PW'(new_c[1]);
        minus_upd = minus_reg - PW'(old_c[0]) + PW'(new_c[0]);
        tidx = {!item_reg.treated, !item_reg.succ};
    end

    // Datapath and output register next values.
    always_comb begin
        item_next     = item_reg;
        clr_addr_next = clr_addr_reg;
        init_next     = init_reg;
        tally_next    = tally_reg;
        plus_next     = plus_reg;
        minus_next    = minus_reg;
        max_next      = max_reg;
        mvalid_next   = mvalid_reg && !m_tready;
        mdata_next    = mdata_reg;
        pop           = 1'b0;
        we            = 1'b0;
        wa            = AW'(32'(item_reg.pid) - 32'd1);
        wd            = EW'(new_e);
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid && !init_reg) begin
                    pop       = 1'b1;
                    item_next = q_item;
                    if (q_item.kind == KIND_CLEAR) begin
                        clr_addr_next = '0;
                        for (int i = 0; i < 4; i++) begin
                            tally_next[i] = '0;
                        end
                        plus_next  = '0;
                        minus_next = '0;
                        max_next   = '0;
                    end
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    if (is_obs && item_reg.unmatched) begin
                        if (tally_reg[tidx] != CNT_MAX) begin
                            tally_next[tidx] = tally_reg[tidx] + 1'b1;
                        end
                    end else if (is_obs && item_reg.in_range) begin
                        we         = 1'b1;
                        plus_next  = plus_upd;
                        minus_next = minus_upd;
                        if (item_reg.pid > max_reg) begin
                            max_next = item_reg.pid;
                        end
                    end
                    mvalid_next = 1'b1;
                    mdata_next  = {1'b0, flags, dvalid, diff, sel_e.ctl.val, sel_e.trt.val,
                                   max_next,
                                   (32'(minus_next) > 32'd2047) ? 11'h7FF : 11'(minus_next),
                                   (32'(plus_next) > 32'd2047) ? 11'h7FF : 11'(plus_next),
                                   TALLY_OUT_W'(tally_next[3]), TALLY_OUT_W'(tally_next[2]),
                                   TALLY_OUT_W'(tally_next[1]), TALLY_OUT_W'(tally_next[0])};
                end
            end
            ST_CLEAR: begin
                we            = 1'b1;
                wa            = clr_addr_reg;
                wd            = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == LAST_ADDR) begin
                    init_next = 1'b0;
                end
            end
            ST_REPLY: begin
                if (out_free) begin
                    mvalid_next = 1'b1;
                    mdata_next  = '0;
                end
            end
            default: begin
                mvalid_next = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            init_reg     <= 1'b1;
            mvalid_reg   <= 1'b0;
            plus_reg     <= '0;
            minus_reg    <= '0;
            max_reg      <= '0;
            for (int i = 0; i < 4; i++) begin
                tally_reg[i] <= '0;
            end
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            init_reg     <= init_next;
            mvalid_reg   <= mvalid_next;
            plus_reg     <= plus_next;
            minus_reg    <= minus_next;
            max_reg      <= max_next;
            tally_reg    <= tally_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        item_reg  <= item_next;
        mdata_reg <= mdata_next;
    end

    assign stat.init_busy = init_reg;
    assign stat.pop       = pop;
    assign m_tvalid       = mvalid_reg;
    assign m_tdata        = mdata_reg;

endmodule

/* rtl/matched_pair_outcome_tally.sv */
// Top level of the matched pair outcome tally.
// A result is registered: its item leaves the queue into the item and table read
// registers, and in the execute state the result goes to the result register.
// The back end takes a new item only after the last has passed its table read and write-back.
// A clear item runs a clearing pass through all MAX_PAIRS table entries before its all-zero result.
// Reset clears the counters and starts the same pass, with s_tready low until
// it ends; no result is produced for it.
module matched_pair_outcome_tally #(
    parameter int MAX_PAIRS   = mpot_pkg::MAX_PAIRS_DEF,
    parameter int COUNT_WIDTH = mpot_pkg::COUNT_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // pair_id[10:0], treated[11], outcome[43:12], outcome_finite[44], zeros
    input  logic [mpot_pkg::IN_DATA_W-1:0]  s_tdata,
    // kind[1:0]
    input  logic [1:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // treated_success_count[23:0], treated_failure_count[47:24],
    // control_success_count[71:48], control_failure_count[95:72],
    // discordant_plus[106:96], discordant_minus[117:107], highest_pair[128:118],
    // entry_treated_value[160:129], entry_control_value[192:161],
    // entry_difference[225:193], difference_valid[226], entry_flags[230:227], zero
    output logic [mpot_pkg::OUT_DATA_W-1:0] m_tdata
);
    import mpot_pkg::*;

    back_stat_t stat;
    logic       q_valid;
    item_t      q_item;

    mpot_front #(
        .MAX_PAIRS(MAX_PAIRS)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .stat    (stat),
        .q_valid (q_valid),
        .q_item  (q_item)
    );

    mpot_back #(
        .MAX_PAIRS  (MAX_PAIRS),
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_item  (q_item),
        .stat    (stat),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    // No item is taken in the cycle after reset, while the table is cleared.
    a_init_block: assert property (@(posedge aclk) !aresetn |=> !s_tready)
        else $error("item accepted during clearing pass");

    // Discordant pairs never outnumber the highest pair id.
    a_disc_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (12'(m_tdata[106:96]) + 12'(m_tdata[117:107])) <= 12'(m_tdata[128:118]))
        else $error("discordant counts exceed highest pair");

    // A valid difference means both arms are found and finite.
    a_diff_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[226]) |-> (m_tdata[230:227] == 4'hF))
        else $error("difference valid without full flags");

    // A result with no valid difference carries a zero difference.
    a_diff_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[226]) |-> (m_tdata[225:193] == '0))
        else $error("nonzero difference without valid flag");

endmodule
